[hw/rtl/mers_pkg.sv]
// ----------------------------------------------------------------------------
// mers_pkg: shared types and constants for the edge reversal distance block.
// Holds sizes, command codes, status codes and controller interface structs.
// ----------------------------------------------------------------------------
package mers_pkg;

  localparam int unsigned MaxNodes  = 64;
  localparam int unsigned MaxEdges  = 256;
  localparam int unsigned NodeW     = $clog2(MaxNodes);
  localparam int unsigned EdgeW     = $clog2(MaxEdges);
  localparam int unsigned CountW    = EdgeW + 1;
  localparam int unsigned NcW       = 7;
  localparam int unsigned DistW     = 7;
  localparam logic [DistW-1:0] DistInf = 7'd127;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_RUN   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_SELECT,
    S_SCAN,
    S_EMIT,
    S_RESP
  } state_e;

  typedef enum logic [1:0] {
    SCAN_EDGE,
    SCAN_NODE,
    SCAN_RELAX
  } scan_ph_e;

  typedef struct packed {
    logic init_start;
    logic init_step;
    logic sel_start;
    logic sel_step;
    logic settle;
    logic scan_start;
    logic scan_step;
    logic emit_start;
    logic emit_step;
    logic add_edge;
    logic clear_edges;
  } cmd_t;

  typedef struct packed {
    logic init_done;
    logic sel_done;
    logic sel_found;
    logic scan_done;
    logic emit_last;
    logic add_range_err;
    logic add_full;
    logic src_range_err;
  } sts_t;

endpackage

[hw/rtl/mers_ctrl.sv]
// ----------------------------------------------------------------------------
// mers_ctrl: controller state machine.
// Sequences init, select, scan and emit phases and drives the handshakes.
// ----------------------------------------------------------------------------
module mers_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_ready,
  input  mers_pkg::kind_e    kind_i,
  input  mers_pkg::sts_t     sts_i,
  output mers_pkg::cmd_t     cmd_o,
  output logic               out_valid,
  input  logic               out_ready,
  output mers_pkg::status_e  status_o,
  output logic               emit_o,
  output logic               last_o
);
  import mers_pkg::*;

  state_e    state_q, state_d;
  status_e   status_q, status_d;
  logic      in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    status_d  = status_q;
    cmd_o     = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    emit_o    = 1'b0;
    last_o    = 1'b1;
    status_o  = status_q;
    case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_acc) begin
          case (kind_i)
            KIND_ADD: begin
              state_d = S_RESP;
              if (sts_i.add_range_err) begin
                status_d = ST_RANGE;
              end else if (sts_i.add_full) begin
                status_d = ST_FULL;
              end else begin
                status_d = ST_OK;
                cmd_o.add_edge = 1'b1;
              end
            end
            KIND_CLEAR: begin
              state_d = S_RESP;
              status_d = ST_OK;
              cmd_o.clear_edges = 1'b1;
            end
            KIND_RUN: begin
              if (sts_i.src_range_err) begin
                state_d  = S_RESP;
                status_d = ST_RANGE;
              end else begin
                state_d  = S_INIT;
                status_d = ST_OK;
                cmd_o.init_start = 1'b1;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_INIT: begin
        cmd_o.init_step = 1'b1;
        if (sts_i.init_done) begin
          state_d = S_SELECT;
          cmd_o.sel_start = 1'b1;
        end
      end
      S_SELECT: begin
        if (sts_i.sel_done) begin
          if (sts_i.sel_found) begin
            cmd_o.settle     = 1'b1;
            cmd_o.scan_start = 1'b1;
            state_d = S_SCAN;
          end else begin
            cmd_o.emit_start = 1'b1;
            state_d = S_EMIT;
          end
        end else begin
          cmd_o.sel_step = 1'b1;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          cmd_o.sel_start = 1'b1;
          state_d = S_SELECT;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        emit_o    = 1'b1;
        last_o    = sts_i.emit_last;
        if (out_acc) begin
          cmd_o.emit_step = 1'b1;
          if (sts_i.emit_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_RESP: begin
        out_valid = 1'b1;
        if (out_acc) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[hw/rtl/mers_dp.sv]
// ----------------------------------------------------------------------------
// mers_dp: datapath with edge store, distance table and scan counters.
// Runs a node-by-node minimum search and a linear edge scan per round.
// ----------------------------------------------------------------------------
module mers_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mers_pkg::NcW-1:0]      node_count_i,
  input  logic [mers_pkg::NodeW-1:0]    from_node_i,
  input  logic [mers_pkg::NodeW-1:0]    to_node_i,
  input  mers_pkg::cmd_t                cmd_i,
  output mers_pkg::sts_t                sts_o,
  output logic [mers_pkg::NodeW-1:0]    node_index_o,
  output logic [mers_pkg::NodeW-1:0]    distance_o,
  output logic                          reachable_o
);
  import mers_pkg::*;

  logic [2*NodeW-1:0]  edge_mem [MaxEdges];
  logic [DistW:0]      node_mem [MaxNodes];

  logic [CountW-1:0]   ecount_q;
  logic [NcW-1:0]      n_live;
  logic [NodeW-1:0]    src_q;
  logic [NodeW:0]      ptr_q, ptr_d;
  logic [NodeW-1:0]    best_q;
  logic [DistW-1:0]    bd_q;
  logic                found_q;
  logic [CountW-1:0]   eidx_q;
  scan_ph_e            sph_q;
  logic [2*NodeW-1:0]  rd_q;
  logic [DistW:0]      rda_q, rdb_q;
  logic [NodeW-1:0]    rt, rh, addr_a;
  logic [DistW-1:0]    cand_h, cand_t;
  logic                ptr_end, edge_live, relax_h, relax_t;

  always_comb begin
    n_live = node_count_i;
    if (node_count_i == '0) n_live = NcW'(1);
    if (node_count_i > NcW'(MaxNodes)) n_live = NcW'(MaxNodes);
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.init_step || cmd_i.sel_step || cmd_i.emit_step) ptr_d = ptr_q + 1'b1;
    if (cmd_i.init_start || cmd_i.sel_start || cmd_i.emit_start) ptr_d = '0;
  end

  assign ptr_end = (ptr_q >= n_live);
  assign sts_o.add_range_err = ({1'b0, from_node_i} >= n_live) ||
                               ({1'b0, to_node_i} >= n_live);
  assign sts_o.add_full      = (ecount_q >= CountW'(MaxEdges));
  assign sts_o.src_range_err = ({1'b0, from_node_i} >= n_live);
  assign sts_o.init_done     = (ptr_q == (NodeW+1)'(MaxNodes - 1));
  assign sts_o.sel_done      = ptr_end;
  assign sts_o.sel_found     = found_q;
  assign sts_o.scan_done     = (eidx_q >= ecount_q) && (sph_q == SCAN_EDGE);
  assign sts_o.emit_last     = ({1'b0, ptr_q} + 1'b1 == {1'b0, n_live});

  assign node_index_o = ptr_q[NodeW-1:0];
  assign reachable_o  = (rda_q[DistW-1:0] != DistInf);
  assign distance_o   = reachable_o ? rda_q[NodeW-1:0] : '0;

  assign rt        = rd_q[2*NodeW-1:NodeW];
  assign rh        = rd_q[NodeW-1:0];
  assign cand_h    = bd_q;
  assign cand_t    = bd_q + 1'b1;
  assign addr_a    = (sph_q == SCAN_NODE) ? rt : ptr_d[NodeW-1:0];
  assign edge_live = ({1'b0, rt} < n_live) && ({1'b0, rh} < n_live);
  assign relax_h   = cmd_i.scan_step && (sph_q == SCAN_RELAX) && edge_live &&
                     (rt == best_q) && !rdb_q[DistW] && (cand_h < rdb_q[DistW-1:0]);
  assign relax_t   = cmd_i.scan_step && (sph_q == SCAN_RELAX) && edge_live &&
                     (rh == best_q) && !rda_q[DistW] && (cand_t < rda_q[DistW-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_edge) begin
      edge_mem[ecount_q[EdgeW-1:0]] <= {from_node_i, to_node_i};
    end
    rd_q <= edge_mem[eidx_q[EdgeW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_step) begin
      node_mem[ptr_q[NodeW-1:0]] <= (ptr_q[NodeW-1:0] == src_q) ?
                                    {1'b0, DistW'(0)} : {1'b0, DistInf};
    end else if (cmd_i.settle) begin
      node_mem[best_q] <= {1'b1, bd_q};
    end else if (relax_h) begin
      node_mem[rh] <= {1'b0, cand_h};
    end else if (relax_t) begin
      node_mem[rt] <= {1'b0, cand_t};
    end
    rda_q <= node_mem[addr_a];
    rdb_q <= node_mem[rh];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecount_q <= '0;
      ptr_q    <= '0;
      eidx_q   <= '0;
      sph_q    <= SCAN_EDGE;
      found_q  <= 1'b0;
      src_q    <= '0;
      best_q   <= '0;
      bd_q     <= DistInf;
    end else begin
      ptr_q <= ptr_d;
      if (cmd_i.clear_edges) ecount_q <= '0;
      else if (cmd_i.add_edge) ecount_q <= ecount_q + 1'b1;
      if (cmd_i.init_start) src_q <= from_node_i;
      if (cmd_i.sel_start || cmd_i.emit_start) begin
        found_q <= 1'b0;
        bd_q    <= DistInf;
      end else if (cmd_i.sel_step && !rda_q[DistW] && (rda_q[DistW-1:0] < bd_q)) begin
        bd_q    <= rda_q[DistW-1:0];
        best_q  <= ptr_q[NodeW-1:0];
        found_q <= 1'b1;
      end
      if (cmd_i.scan_start) begin
        eidx_q <= '0;
        sph_q  <= SCAN_EDGE;
      end else if (cmd_i.scan_step) begin
        case (sph_q)
          SCAN_EDGE: sph_q <= SCAN_NODE;
          SCAN_NODE: sph_q <= SCAN_RELAX;
          SCAN_RELAX: begin
            sph_q  <= SCAN_EDGE;
            eidx_q <= eidx_q + 1'b1;
          end
          default: sph_q <= SCAN_EDGE;
        endcase
      end
    end
  end

endmodule

[hw/rtl/min_edge_reversal_shortest_path_top.sv]
// ----------------------------------------------------------------------------
// min_edge_reversal_shortest_path_top: minimum edge reversal distances.
// Edge store with add and clear, and a run that reports each node's distance.
// Add, clear and refused items: the status beat is offered in the cycle after the
// input is taken, and the next input is taken in idle, after that beat is accepted.
// A run writes all 64 distance entries, then per settled node a select pass over n nodes
// and an edge, node, relax scan of each edge, then a last select pass and n result beats.
// Reset empties the edge store and sets node_count to 64.
// ----------------------------------------------------------------------------
module min_edge_reversal_shortest_path_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 kind_i,
  input  logic [5:0]                 from_node_i,
  input  logic [5:0]                 to_node_i,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [6:0]                 node_count_i,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 status_o,
  output logic [5:0]                 node_index_o,
  output logic [5:0]                 distance_o,
  output logic                       reachable_o,
  output logic                       last_o
);
  import mers_pkg::*;

  logic [NcW-1:0]   node_count_q;
  cmd_t             cmd;
  sts_t             sts;
  status_e          status;
  logic             emit;
  logic [NodeW-1:0] idx, dist_val;
  logic             reach;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NcW'(MaxNodes);
    end else if (cfg_valid && cfg_ready) begin
      node_count_q <= node_count_i;
    end
  end

  mers_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind_i    (kind_e'(kind_i)),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status_o  (status),
    .emit_o    (emit),
    .last_o    (last_o)
  );

  mers_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .node_count_i (node_count_q),
    .from_node_i  (from_node_i),
    .to_node_i    (to_node_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .node_index_o (idx),
    .distance_o   (dist_val),
    .reachable_o  (reach)
  );

  assign status_o     = status;
  assign node_index_o = emit ? idx : '0;
  assign distance_o   = emit ? dist_val : '0;
  assign reachable_o  = emit ? reach : 1'b0;

  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_run_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && reachable_o) |-> (status_o == ST_OK))
    else $error("reachable flag on refused item");
  a_add_clear_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.add_edge && cmd.clear_edges)) else $error("add and clear together");

endmodule
